### design/btmx_pkg.sv
// ----------------------------------------------------------------------------
// btmx_pkg
// shared constants and types of the binary trie maximum xor unit
// ----------------------------------------------------------------------------
package btmx_pkg;

  localparam int KeyW           = 32;
  localparam int KeyBitsDef     = 32;
  localparam int NodeCountDef   = 4096;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_ANSWERED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } state_e;

endpackage

### design/btmx_in_if.sv
// ----------------------------------------------------------------------------
// btmx_in_if
// input channel: one insert or query word
// ----------------------------------------------------------------------------
interface btmx_in_if
  import btmx_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            kind;
  logic [KeyW-1:0] key;

  modport source (output valid, kind, key, input ready);
  modport sink   (input valid, kind, key, output ready);
endinterface

### design/btmx_out_if.sv
// ----------------------------------------------------------------------------
// btmx_out_if
// output channel: one result word
// ----------------------------------------------------------------------------
interface btmx_out_if
  import btmx_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [KeyW-1:0] max_xor;

  modport source (output valid, status, max_xor, input ready);
  modport sink   (input valid, status, max_xor, output ready);
endinterface

### design/btmx_ram.sv
// ----------------------------------------------------------------------------
// btmx_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module btmx_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/binary_trie_max_xor_unit.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit
// bitwise binary trie of unsigned keys with insert and maximum xor query
// ----------------------------------------------------------------------------
// Each input word either inserts its key into the trie or asks for the
// greatest xor of its key with any stored key; every word gives exactly one
// result word. Words are handled one at a time: the word is taken, then the
// trie is walked one key bit per cycle, with one read of the node store per
// level, then the result moves into the output register once the output
// slot is free. A refused insert or a query on an empty trie skips the walk.
// A waiting result does not block the next word from being taken. Nodes come
// from a bump counter and are never freed; an insert is refused when fewer
// than KEY_BITS nodes remain. The root sits in flip-flops, so no clearing
// pass follows reset.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_unit
  import btmx_pkg::*;
#(
  parameter int KEY_BITS   = KeyBitsDef,
  parameter int NODE_COUNT = NodeCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  btmx_in_if.sink     in_i,
  btmx_out_if.source  out_o
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int FW = AW + 1;
  localparam int LW = $clog2(KEY_BITS);
  localparam int LinkW = 2 * AW;
  localparam logic [FW-1:0] FullAt = FW'(NODE_COUNT - KEY_BITS);

  state_e state_q, state_d;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] acc_q, acc_d;
  logic [AW-1:0]       node_q, node_d;
  logic [LW-1:0]       lvl_q, lvl_d;
  logic                fresh_q, fresh_d;
  logic                dead_q, dead_d;
  logic                kind_q, kind_d;
  status_e             status_q, status_d;
  logic [FW-1:0]       free_q, free_d;
  logic                has_keys_q, has_keys_d;
  logic [LinkW-1:0]    root_q, root_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [KeyW-1:0]     out_xor_q, out_xor_d;

  logic                in_fire, out_fire, slot_free, full, early;
  logic                bit_cur, bit_other;
  logic [LinkW-1:0]    rd_data, cur, upd;
  logic [AW-1:0]       link_same, link_other, alloc;
  logic                we;

  btmx_ram #(
    .Width (LinkW),
    .Depth (NODE_COUNT)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (node_q),
    .wdata_i (upd),
    .raddr_i (node_d),
    .rdata_o (rd_data)
  );

  assign in_fire   = in_i.valid & in_i.ready;
  assign out_fire  = out_valid_q & out_o.ready;
  assign slot_free = ~out_valid_q | out_o.ready;
  assign full      = free_q > FullAt;
  assign early     = (in_i.kind == KIND_INSERT) ? full : ~has_keys_q;

  assign bit_cur    = key_q[KEY_BITS-1];
  assign bit_other  = ~bit_cur;
  assign cur        = (node_q == '0) ? root_q : (fresh_q ? '0 : rd_data);
  assign link_same  = cur[bit_cur*AW +: AW];
  assign link_other = cur[bit_other*AW +: AW];
  assign alloc      = free_q[AW-1:0];

  always_comb begin
    upd = cur;
    upd[bit_cur*AW +: AW] = alloc;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = early ? S_HOLD : S_WALK;
        end
      end
      S_WALK: begin
        if (lvl_q == '0) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    key_d        = key_q;
    acc_d        = acc_q;
    node_d       = node_q;
    lvl_d        = lvl_q;
    fresh_d      = fresh_q;
    dead_d       = dead_q;
    kind_d       = kind_q;
    status_d     = status_q;
    free_d       = free_q;
    has_keys_d   = has_keys_q;
    root_d       = root_q;
    we           = 1'b0;
    out_valid_d  = out_valid_q & ~out_fire;
    out_status_d = out_status_q;
    out_xor_d    = out_xor_q;
    in_i.ready   = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          kind_d  = in_i.kind;
          key_d   = in_i.key[KEY_BITS-1:0];
          acc_d   = '0;
          node_d  = '0;
          lvl_d   = LW'(KEY_BITS - 1);
          fresh_d = 1'b0;
          dead_d  = 1'b0;
          if (in_i.kind == KIND_INSERT) begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              status_d   = ST_INSERTED;
              has_keys_d = 1'b1;
            end
          end else begin
            status_d = has_keys_q ? ST_ANSWERED : ST_EMPTY;
          end
        end
      end
      S_WALK: begin
        key_d = key_q << 1;
        lvl_d = lvl_q - LW'(1);
        if (kind_q == KIND_INSERT) begin
          if (fresh_q || (link_same == '0)) begin
            free_d  = free_q + FW'(1);
            fresh_d = 1'b1;
            node_d  = alloc;
            if (node_q == '0) begin
              root_d = upd;
            end else begin
              we = 1'b1;
            end
          end else begin
            node_d = link_same;
          end
        end else begin
          if (dead_q) begin
            acc_d = {acc_q[KEY_BITS-2:0], 1'b0};
          end else if (link_other != '0) begin
            acc_d  = {acc_q[KEY_BITS-2:0], 1'b1};
            node_d = link_other;
          end else if (link_same != '0) begin
            acc_d  = {acc_q[KEY_BITS-2:0], 1'b0};
            node_d = link_same;
          end else begin
            acc_d  = {acc_q[KEY_BITS-2:0], 1'b0};
            dead_d = 1'b1;
          end
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_xor_d    = KeyW'(acc_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      free_q      <= FW'(1);
      has_keys_q  <= 1'b0;
      root_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      free_q      <= free_d;
      has_keys_q  <= has_keys_d;
      root_q      <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    acc_q        <= acc_d;
    node_q       <= node_d;
    lvl_q        <= lvl_d;
    fresh_q      <= fresh_d;
    dead_q       <= dead_d;
    kind_q       <= kind_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_xor_q    <= out_xor_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.max_xor = out_xor_q;

endmodule

### bench/binary_trie_max_xor_unit_test.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit_test
// self-checking bench for the binary trie maximum xor unit
// ----------------------------------------------------------------------------
// Sends insert and query words with random gaps and collects result words
// behind random output stalls. A behavioral trie predicts every result, and
// results are checked in order. The run covers queries on an empty trie,
// extreme keys, duplicate inserts, a long random mix of clustered and spread
// keys, and inserts refused once the node store runs low.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import btmx_pkg::*;

  localparam int KeyBits       = KeyBitsDef;
  localparam int NodeCount     = NodeCountDef;
  localparam int RandomWords   = 1900;
  localparam int DrainCycles   = KeyBits + 8;
  localparam int WatchdogLimit = 400;

  typedef struct packed {
    status_e         status;
    logic [KeyW-1:0] max_xor;
  } trie_result_t;

  logic clk_i;
  logic rst_ni;

  btmx_in_if  in_if ();
  btmx_out_if out_if ();

  binary_trie_max_xor_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  int unsigned     trie_link [NodeCount][2];
  int unsigned     free_node = 1;
  bit              trie_loaded;
  trie_result_t    awaited_results [$];
  logic [KeyW-1:0] known_keys [$];
  logic [KeyW-1:0] cluster_base [8];
  bit              no_idle;
  int              fail_count;
  int              idle_cycles;
  int              n_inserted;
  int              n_refused;
  int              n_answered;
  int              n_empty;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic trie_result_t trie_apply(input logic kind, input logic [KeyW-1:0] raw_key);
    trie_result_t    res;
    logic [KeyW-1:0] key;
    int unsigned     node;
    int unsigned     nxt;
    int unsigned     side;
    int              lvl;
    bit              stuck;
    key = raw_key & ({KeyW{1'b1}} >> (KeyW - KeyBits));
    res.max_xor = '0;
    node = 0;
    stuck = 1'b0;
    if (kind == KIND_INSERT) begin
      if (free_node > NodeCount || NodeCount - free_node < KeyBits) begin
        res.status = ST_FULL;
      end else begin
        for (lvl = KeyBits - 1; lvl >= 0; lvl--) begin
          side = key[lvl];
          nxt = trie_link[node][side];
          if (nxt == 0) begin
            nxt = free_node;
            free_node++;
            trie_link[nxt][0] = 0;
            trie_link[nxt][1] = 0;
            trie_link[node][side] = nxt;
          end
          node = nxt;
        end
        trie_loaded = 1'b1;
        res.status = ST_INSERTED;
      end
    end else if (!trie_loaded) begin
      res.status = ST_EMPTY;
    end else begin
      for (lvl = KeyBits - 1; lvl >= 0 && !stuck; lvl--) begin
        side = key[lvl];
        if (trie_link[node][side ^ 1] != 0) begin
          res.max_xor[lvl] = 1'b1;
          node = trie_link[node][side ^ 1];
        end else if (trie_link[node][side] != 0) begin
          node = trie_link[node][side];
        end else begin
          stuck = 1'b1;
        end
      end
      res.status = ST_ANSWERED;
    end
    return res;
  endfunction

  function automatic logic [KeyW-1:0] known_or_random();
    logic [KeyW-1:0] pick;
    if (known_keys.size() == 0) return $urandom();
    pick = known_keys[$urandom_range(0, known_keys.size() - 1)];
    return $urandom_range(0, 1) ? ~pick : pick;
  endfunction

  function automatic logic [KeyW-1:0] cluster_key();
    return cluster_base[$urandom_range(0, 7)] ^ KeyW'($urandom_range(0, 255));
  endfunction

  function automatic logic [KeyW-1:0] query_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return cluster_key();
      6, 7:             return known_or_random();
      default:          return $urandom();
    endcase
  endfunction

  function automatic logic [KeyW-1:0] insert_key();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return known_keys.size() > 0 ?
                      known_keys[$urandom_range(0, known_keys.size() - 1)] : $urandom();
      default: return cluster_key();
    endcase
  endfunction

  task automatic send_word(input logic kind, input logic [KeyW-1:0] key);
    int           gap;
    trie_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.key   <= key;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    res = trie_apply(kind, key);
    awaited_results.insert(awaited_results.size(), res);
    case (res.status)
      ST_INSERTED: begin
        n_inserted++;
        known_keys.insert(known_keys.size(), key);
      end
      ST_FULL:     n_refused++;
      ST_ANSWERED: n_answered++;
      default:     n_empty++;
    endcase
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_trie();
    send_word(KIND_QUERY, 32'h0000_0000);
    send_word(KIND_QUERY, 32'hFFFF_FFFF);
    send_word(KIND_QUERY, 32'h8000_0000);
    send_word(KIND_QUERY, $urandom());
  endtask

  task automatic test_edge_keys();
    send_word(KIND_INSERT, 32'h0000_0000);
    send_word(KIND_QUERY,  32'h0000_0000);
    send_word(KIND_QUERY,  32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'hFFFF_FFFF);
    send_word(KIND_QUERY,  32'h0000_0000);
    send_word(KIND_QUERY,  32'h0000_FFFF);
    send_word(KIND_INSERT, 32'h0000_0000);
    send_word(KIND_INSERT, 32'h8000_0000);
    send_word(KIND_INSERT, 32'h0000_0001);
    send_word(KIND_INSERT, 32'h7FFF_FFFF);
    send_word(KIND_QUERY,  32'h8000_0000);
    send_word(KIND_QUERY,  32'h7FFF_FFFF);
    send_word(KIND_QUERY,  32'h5555_5555);
    send_word(KIND_QUERY,  32'hAAAA_AAAA);
    send_word(KIND_QUERY,  32'hFFFF_FFFE);
  endtask

  task automatic test_random_mix();
    int n;
    foreach (cluster_base[c]) cluster_base[c] = $urandom();
    for (n = 0; n < RandomWords; n++) begin
      no_idle = (n >= 400 && n < 600);
      if (n == RandomWords / 2) wait_drained();
      if ($urandom_range(0, 9) < 3) send_word(KIND_INSERT, insert_key());
      else send_word(KIND_QUERY, query_key());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_store_full();
    while (free_node <= NodeCount - KeyBits) send_word(KIND_INSERT, $urandom());
    send_word(KIND_INSERT, known_keys[0]);
    send_word(KIND_INSERT, 32'h0000_0000);
    send_word(KIND_INSERT, 32'hFFFF_FFFF);
    send_word(KIND_INSERT, $urandom());
    send_word(KIND_QUERY,  32'h0000_0000);
    send_word(KIND_QUERY,  32'hFFFF_FFFF);
    send_word(KIND_QUERY,  known_or_random());
    send_word(KIND_QUERY,  $urandom());
  endtask

  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  always @(posedge clk_i) begin : check_results
    trie_result_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word, status %0d max_xor %h", $time,
                 out_if.status, out_if.max_xor);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_if.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_if.status);
          fail_count++;
        end
        if (out_if.max_xor !== want.max_xor) begin
          $display("%0t: max_xor expected %h got %h", $time, want.max_xor, out_if.max_xor);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, WatchdogLimit);
      $display("binary_trie_max_xor_unit_test failed");
      $finish;
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.kind  <= KIND_INSERT;
    in_if.key   <= '0;
    rst_ni      <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_trie();
    wait_drained();
    test_edge_keys();
    wait_drained();
    test_random_mix();
    wait_drained();
    test_store_full();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d inserts, %0d refused on a full store, %0d queries answered,",
             n_inserted, n_refused, n_answered);
    $display("%0d queries on an empty trie, %0d of %0d trie nodes in use at the end",
             n_empty, free_node, NodeCount);
    if (fail_count == 0) begin
      $display("binary_trie_max_xor_unit_test passed");
    end else begin
      $display("binary_trie_max_xor_unit_test failed");
    end
    $finish;
  end

endmodule
